// ----- hdl/ssmt_pkg.sv -----
// Shared types, constants and helpers of the sorted subnet membership table.
// No dependencies; imported by the request interface, the cell and the top level.
package ssmt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PlenW = 6;
  localparam int unsigned ReqW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } ctrl_state_e;

  // Broadcast command to every cell for the accepted beat
  typedef struct packed {
    logic             load;
    logic             clear;
    logic             query;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] qaddr;
  } cell_cmd_t;

  // What a cell hands to its right-hand neighbor
  typedef struct packed {
    logic             valid;
    logic             ins;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] mask;
  } cell_link_t;

  // Prefix length to mask; lengths above 32 saturate to all ones
  function automatic logic [AddrW-1:0] build_mask(input logic [PlenW-1:0] plen);
    logic [PlenW-1:0] p;
    p = (plen > PlenW'(AddrW)) ? PlenW'(AddrW) : plen;
    if (p == '0) begin
      build_mask = '0;
    end else begin
      build_mask = {AddrW{1'b1}} << (PlenW'(AddrW) - p);
    end
  endfunction

endpackage

// ----- hdl/ssmt_req_if.sv -----
// Request channel: valid/ready plus the request payload.
// Depends on ssmt_pkg for field widths.
interface ssmt_req_if import ssmt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [AddrW-1:0] entry_addr;
  logic [PlenW-1:0] prefix_len;
  logic [AddrW-1:0] query_addr;

  modport source (output valid, req_type, entry_addr, prefix_len, query_addr, input ready);
  modport sink   (input valid, req_type, entry_addr, prefix_len, query_addr, output ready);
endinterface

// ----- hdl/ssmt_rsp_if.sv -----
// Response channel: valid/ready plus match and status.
// No package dependency.
interface ssmt_rsp_if ();
  logic valid;
  logic ready;
  logic match;
  logic status;

  modport source (output valid, match, status, input ready);
  modport sink   (input valid, match, status, output ready);
endinterface

// ----- hdl/sorted_subnet_membership_table.sv -----
// Top level of the sorted subnet membership table: control, cell chain, output register.
// Depends on ssmt_pkg, ssmt_req_if, ssmt_rsp_if and ssmt_cell.
//
// Usage: requests arrive on req_i (valid/ready); each beat is a clear, a load
// (entry_addr, prefix_len) or a query (query_addr). Every request beat yields
// exactly one response beat on rsp_o with match and status.
// Entries live in a chain of MAX_ENTRIES cells kept sorted by base address;
// a load shifts the cells right of the insertion point by one, all together,
// and a query compares all cells at once against the address.
// The request beat is registered into the evaluate state, and the response
// register loads from the evaluate state once it is free. A new request is
// taken only in the idle state; the evaluate step gathers the registered
// per-cell hit flags into the response register.
// A full table drops the load and returns status 1.
// Stall: a new request may be taken while the response waits; its result is
// held in the evaluate state until the response register is taken.
// Reset: rst_ni clears all cell valid flags (table empty) and the response.
module sorted_subnet_membership_table import ssmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssmt_req_if.sink   req_i,
  ssmt_rsp_if.source rsp_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        full;
  req_type_e   req_type;
  logic        is_query_q, is_query_d;
  logic        drop_q, drop_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        rsp_match_q, rsp_match_d;
  logic        rsp_status_q, rsp_status_d;
  logic        out_free;
  cell_cmd_t   cmd;

  cell_link_t links [MAX_ENTRIES];
  cell_link_t lefts [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le_vec;
  logic [MAX_ENTRIES-1:0] right_le;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_type    = req_type_e'(req_i.req_type);
  assign full        = links[MAX_ENTRIES-1].valid;

  // Broadcast command
  always_comb begin
    cmd.load  = accept && (req_type == REQ_LOAD) && !full;
    cmd.clear = accept && (req_type == REQ_CLEAR);
    cmd.query = accept && (req_type == REQ_QUERY);
    cmd.mask  = build_mask(req_i.prefix_len);
    cmd.base  = req_i.entry_addr & cmd.mask;
    cmd.qaddr = req_i.query_addr;
  end

  // Cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '{valid: 1'b1, ins: 1'b0, base: '0, mask: '0};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_le[i] = 1'b0;
    end else begin : g_inner
      assign right_le[i] = le_vec[i+1];
    end
    assign valid_vec[i] = links[i].valid;

    ssmt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     (lefts[i]),
      .right_le_i (right_le[i]),
      .link_o     (links[i]),
      .le_o       (le_vec[i]),
      .hit_o      (hit_vec[i])
    );
  end

  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Control and response register
  always_comb begin
    state_d      = state_q;
    is_query_d   = is_query_q;
    drop_d       = drop_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_match_d  = rsp_match_q;
    rsp_status_d = rsp_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_EVAL;
          is_query_d = (req_type == REQ_QUERY);
          drop_d     = (req_type == REQ_LOAD) && full;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          state_d      = S_IDLE;
          rsp_valid_d  = 1'b1;
          rsp_match_d  = is_query_q && (|hit_vec);
          rsp_status_d = drop_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_query_q   <= is_query_d;
    drop_q       <= drop_d;
    rsp_match_q  <= rsp_match_d;
    rsp_status_q <= rsp_status_d;
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.match  = rsp_match_q;
  assign rsp_o.status = rsp_status_q;

  // Checks
  a_rsp_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == S_EVAL))
    else $error("response raised without an evaluate cycle");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + MAX_ENTRIES'(1)) & valid_vec) == '0)
    else $error("cell valid flags not contiguous from the head");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |=> (valid_vec == '0))
    else $error("clear left entries in the table");

  a_drop_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> !rsp_o.match)
    else $error("dropped load reported a match");

endmodule

// ----- hdl/ssmt_cell.sv -----
// One slot of the sorted chain: holds a base/mask pair and shifts right on insert.
// Depends on ssmt_pkg.
module ssmt_cell import ssmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  cell_link_t left_i,
  input  logic       right_le_i,
  output cell_link_t link_o,
  output logic       le_o,
  output logic       hit_o
);

  logic             valid_q, valid_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] mask_q, mask_d;
  logic             hit_q, hit_d;
  logic             ins;

  // At or past the insertion point for the new base
  assign ins = !(valid_q && (base_q <= cmd_i.base));
  // Base at or below the query address
  assign le_o = valid_q && (base_q <= cmd_i.qaddr);

  assign link_o = '{valid: valid_q, ins: ins, base: base_q, mask: mask_q};
  assign hit_o  = hit_q;

  // Next slot content
  always_comb begin
    valid_d = valid_q;
    base_d  = base_q;
    mask_d  = mask_q;
    hit_d   = hit_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end
    if (cmd_i.load && ins) begin
      valid_d = valid_q | left_i.valid;
      if (left_i.ins) begin
        base_d = left_i.base;
        mask_d = left_i.mask;
      end else begin
        base_d = cmd_i.base;
        mask_d = cmd_i.mask;
      end
    end
    // Predecessor is the last cell at or below the query
    if (cmd_i.query) begin
      hit_d = le_o && !right_le_i && ((cmd_i.qaddr & mask_q) == base_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mask_q <= mask_d;
  end

endmodule
